FILE: rtl/core/madf_pkg.sv
// madf_pkg: shared types and constants for the moving average distance filter.
// No dependencies.
package madf_pkg;

  // Width of one held sample (non-negative part of a signed Q8.8 reading).
  localparam int SAMPLE_W = 15;

  // Width of the raw input reading.
  localparam int RAW_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/madf_cell.sv
// madf_cell: one window slot; holds a sample and passes it on to its neighbor.
// Depends on madf_pkg.
module madf_cell (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic [madf_pkg::SAMPLE_W-1:0]  d,
  output logic [madf_pkg::SAMPLE_W-1:0]  q
);

  // Advance the window by one slot on each accepted non-negative sample.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/core/madf_div.sv
// madf_div: restoring divider, one quotient bit per cycle.
// No package dependencies; widths come from the parent.
module madf_div #(
  parameter int SUM_W = 18,
  parameter int CNT_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] steps_left;
  logic              busy;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;

  assign shifted = {rem, quotient[SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload: shift the remainder/quotient pair, keep the trial if it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[CNT_W]) begin
        rem      <= trial[CNT_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[CNT_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/moving_average_distance_filter.sv
// moving_average_distance_filter: top level of the window-average filter.
// Depends on madf_pkg, madf_cell and madf_div.
//
// Usage:
//   Input channel (in_valid / in_ready / distance_sample) carries one signed
//   Q8.8 distance reading per request. Output channel (out_valid / out_ready /
//   filtered_distance / sample_rejected) returns exactly one result per input.
//   A negative reading is answered with filtered_distance = 0 and
//   sample_rejected = 1 and leaves the window untouched. Any other reading is
//   pushed into a row of WINDOW cells, the oldest falling off once it is full;
//   the result is the sum of held samples divided by their count, truncated.
// Flow:
//   A valid reading is worked by the bit-serial divider, one quotient bit per
//   cycle over the SUM_W-bit running sum; a rejected reading skips the
//   divider. One request is in work at a time: with the receiver ready the
//   next is taken once the last result has entered the output register.
//   in_ready is high whenever no request is being worked on, even while a
//   finished result waits.
// Reset: rst (synchronous, active high) empties the window and clears the
//   running sum; cell contents are not cleared and are only read once written.
// Stall: if out_ready stays low, the finished result waits in the output
//   register and the next finished result waits in ST_DONE until taken.
module moving_average_distance_filter #(
  parameter int WINDOW = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [madf_pkg::RAW_W-1:0] distance_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [madf_pkg::SAMPLE_W-1:0] filtered_distance,
  output logic                          sample_rejected
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = madf_pkg::SAMPLE_W + $clog2(WINDOW);

  madf_pkg::state_t state, state_next;

  logic [CNT_W-1:0] fill_count;
  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic             pend_rej;
  logic             window_full;
  logic             accept;
  logic             is_neg;
  logic             div_start;
  logic             load_out;
  logic             div_done;
  logic [SUM_W-1:0] quotient;
  logic [madf_pkg::SAMPLE_W-1:0] new_sample;
  logic [madf_pkg::SAMPLE_W-1:0] cell_q [WINDOW];
  logic [madf_pkg::SAMPLE_W-1:0] dropped;

  assign accept      = in_valid && in_ready;
  assign is_neg      = distance_sample[madf_pkg::RAW_W-1];
  assign new_sample  = distance_sample[madf_pkg::SAMPLE_W-1:0];
  assign window_full = (fill_count == CNT_W'(WINDOW));

  // Row of cells: slot 0 takes the new sample, the last slot holds the oldest.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      madf_cell u_cell (
        .clk      (clk),
        .shift_en (accept && !is_neg),
        .d        (new_sample),
        .q        (cell_q[i])
      );
    end else begin : g_body
      madf_cell u_cell (
        .clk      (clk),
        .shift_en (accept && !is_neg),
        .d        (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  // Drop the oldest sample from the sum only once the row is full.
  assign dropped = window_full ? cell_q[WINDOW-1] : '0;

  always_comb begin
    running_sum_next = running_sum + SUM_W'(new_sample) - SUM_W'(dropped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      running_sum <= '0;
    end else if (accept && !is_neg) begin
      running_sum <= running_sum_next;
      if (!window_full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Divider sees the updated sum and count in the cycle after accept.
  madf_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      madf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = is_neg ? madf_pkg::ST_DONE : madf_pkg::ST_DIVIDE;
        end
      end
      madf_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = madf_pkg::ST_DONE;
        end
      end
      madf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = madf_pkg::ST_IDLE;
        end
      end
      default: state_next = madf_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      madf_pkg::ST_IDLE:   in_ready = 1'b1;
      madf_pkg::ST_DIVIDE: in_ready = 1'b0;
      madf_pkg::ST_DONE:   load_out = !out_valid || out_ready;
      default:             in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= madf_pkg::ST_IDLE;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= accept && !is_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rej <= is_neg;
    end
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_rejected   <= pend_rej;
      filtered_distance <= pend_rej ? '0 : quotient[madf_pkg::SAMPLE_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (SUM_W + 1)'(running_sum) <= (SUM_W + 1)'(fill_count) * (SUM_W + 1)'(32767))
    else $error("running sum exceeds count times max sample");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == madf_pkg::ST_DIVIDE)
    else $error("divider finished outside divide state");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_rejected) |-> filtered_distance == '0)
    else $error("rejected result carries nonzero distance");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == madf_pkg::ST_DIVIDE) |-> !accept)
    else $error("request accepted during divide");
`endif

endmodule
